@@ sv/itrt_pkg.sv @@
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the integer to radix text unit
// Widths, the job record passed from front to back, and the digit glyphs.
// ----------------------------------------------------------------------------
package itrt_pkg;

    localparam int VALUE_WIDTH = 32;

    // Radix limits and the fallback radix.
    localparam int BASE_W       = 5;
    localparam int DEFAULT_BASE = 10;
    localparam int MIN_BASE     = 2;
    localparam int MAX_BASE     = 16;

    // Division runs DIV_STEPS restoring steps per cycle on a padded dividend.
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W      = DIV_CYCLES * DIV_STEPS;
    localparam int DIV_CYC_W  = $clog2(DIV_CYCLES + 1);

    // Digit stack: one entry per possible digit.
    localparam int DIGIT_W = 4;
    localparam int STACK_DEPTH = VALUE_WIDTH;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_MINUS       = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO        = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_BIAS  = 7'h57;  // 'a' minus ten

    typedef logic [PAD_W-1:0] t_pad;

    typedef struct packed {
        logic                   neg;
        logic [BASE_W-1:0]      base;
        logic [VALUE_WIDTH-1:0] mag;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_back_state;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DIGIT_W'(DEFAULT_BASE)) begin
            g = CHAR_ZERO + CHAR_W'(d);
        end else begin
            g = CHAR_ALPHA_BIAS + CHAR_W'(d);
        end
        return g;
    endfunction

endpackage

@@ sv/itrt_if.sv @@
// ----------------------------------------------------------------------------
// itrt_if: channel interfaces of the integer to radix text unit
// One interface for the request channel and one for the character channel.
// ----------------------------------------------------------------------------
interface itrt_in_if;
    import itrt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [VALUE_WIDTH-1:0] value;
    logic [7:0]             base;

    modport source (output valid, output mode, output value, output base, input ready);
    modport sink   (input valid, input mode, input value, input base, output ready);
endinterface

interface itrt_out_if;
    import itrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

@@ sv/integer_to_radix_text_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_text_unit: integer to ASCII text in radix 2 to 16
// Converts one value per request into a stream of characters, last marked.
// ----------------------------------------------------------------------------
// A request is mode 0 (unsigned, radix from base, radix 10 when base is
// outside 2 to 16) or mode 1 (signed decimal, a leading '-' for negative
// values). Characters come out most significant digit first, with lower-case
// letters for digits above nine, and last is set on the final beat. The back
// end works on one conversion at a time: it picks up the job, runs the radix
// divider for each digit (eight quotient bits per cycle over the 32-bit
// magnitude), then sends the characters out one by one, '-' included, as the
// output accepts them. A two-entry job queue lets new requests be taken while
// the back end is busy.
module integer_to_radix_text_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itrt_in_if.sink    i_in,
    itrt_out_if.source o_out
);
    import itrt_pkg::*;

    logic q_full, q_empty, q_push, q_pop;
    t_job front_job, back_job;

    itrt_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (front_job)
    );

    itrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (back_job)
    );

    itrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (back_job),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

@@ sv/itrt_front.sv @@
// ----------------------------------------------------------------------------
// itrt_front: request intake and classification
// Picks the effective radix, detects a negative signed value and forms the
// magnitude, then hands the job to the queue.
// ----------------------------------------------------------------------------
module itrt_front (
    itrt_in_if.sink         i_in,
    input  logic            i_q_full,
    output logic            o_q_push,
    output itrt_pkg::t_job  o_q_job
);
    import itrt_pkg::*;

    logic base_ok;

    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    assign base_ok = (i_in.base >= 8'(MIN_BASE)) && (i_in.base <= 8'(MAX_BASE));

    always_comb begin
        o_q_job.neg = i_in.mode && i_in.value[VALUE_WIDTH-1];
        if (i_in.mode || !base_ok) begin
            o_q_job.base = BASE_W'(DEFAULT_BASE);
        end else begin
            o_q_job.base = i_in.base[BASE_W-1:0];
        end
        if (o_q_job.neg) begin
            o_q_job.mag = '0 - i_in.value;
        end else begin
            o_q_job.mag = i_in.value;
        end
    end

endmodule

@@ sv/itrt_queue.sv @@
// ----------------------------------------------------------------------------
// itrt_queue: short job queue between front and back
// A small first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
module itrt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  itrt_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output itrt_pkg::t_job  o_job
);
    import itrt_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ sv/itrt_back.sv @@
// ----------------------------------------------------------------------------
// itrt_back: digit generation and character output
// Divides the magnitude by the radix repeatedly, stacks the remainders and
// pops them most significant first through a registered output beat.
// ----------------------------------------------------------------------------
module itrt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  itrt_pkg::t_job  i_q_job,
    output logic            o_q_pop,
    itrt_out_if.source      o_out
);
    import itrt_pkg::*;

    t_back_state            r_state, n_state;
    t_pad                   r_dvd, n_dvd;
    logic [DIGIT_W-1:0]     r_rem, n_rem;
    logic [DIV_CYC_W-1:0]   r_cyc;
    logic [BASE_W-1:0]      r_base;
    logic                   r_neg;
    logic [DIGIT_W-1:0]     r_stack [STACK_DEPTH];
    logic [STACK_CNT_W-1:0] r_sp;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;

    logic                   slot_free;
    logic                   div_done;
    logic                   load_sign;
    logic                   load_digit;
    logic [STACK_CNT_W-1:0] top_cnt;
    logic [STACK_IDX_W-1:0] top_idx;

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    assign slot_free = !r_out_valid || o_out.ready;
    assign div_done  = (r_state == S_DIV) && (r_cyc == DIV_CYC_W'(DIV_CYCLES - 1));
    assign top_cnt   = r_sp - 1'b1;
    assign top_idx   = top_cnt[STACK_IDX_W-1:0];

    // Restoring division by the radix, DIV_STEPS quotient bits per cycle.
    // The dividend shifts out at the top while quotient bits enter below.
    always_comb begin
        logic [DIGIT_W:0] t;
        logic             q;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {n_rem, n_dvd[PAD_W-1]};
            q = (t >= (DIGIT_W + 1)'(r_base));
            if (q) begin
                t = t - (DIGIT_W + 1)'(r_base);
            end
            n_rem = t[DIGIT_W-1:0];
            n_dvd = {n_dvd[PAD_W-2:0], q};
        end
    end

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        load_sign  = 1'b0;
        load_digit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done && (n_dvd == '0)) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    load_sign = 1'b1;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    load_digit = 1'b1;
                    if (r_sp == STACK_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cyc       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (o_q_pop) begin
                r_cyc <= '0;
                r_sp  <= '0;
            end else if (r_state == S_DIV) begin
                if (div_done) begin
                    r_cyc <= '0;
                    r_sp  <= r_sp + 1'b1;
                end else begin
                    r_cyc <= r_cyc + 1'b1;
                end
            end else if (load_digit) begin
                r_sp <= top_cnt;
            end

            if (load_sign || load_digit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_dvd  <= t_pad'(i_q_job.mag);
            r_rem  <= '0;
            r_base <= i_q_job.base;
            r_neg  <= i_q_job.neg;
        end else if (r_state == S_DIV) begin
            r_dvd <= n_dvd;
            r_rem <= div_done ? '0 : n_rem;
        end

        if (div_done) begin
            r_stack[r_sp[STACK_IDX_W-1:0]] <= n_rem;
        end

        if (load_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (load_digit) begin
            r_char <= digit_glyph(r_stack[top_idx]);
            r_last <= (r_sp == STACK_CNT_W'(1));
        end
    end

endmodule
